// ===== rtl/dhs_pkg.sv =====
// Package for the dual hash seal engine: constants, queue word type and
// the shift-add form of the FNV-1a 64 multiply. No dependencies.
package dhs_pkg;

   localparam logic [63:0] DJB_START = 64'd5381;
   localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] operand;
   } entry_type;

   // The FNV prime is 2^40 + 2^8 + 0xB3, so the product is a sum of shifts.
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
              + (x << 1) + x;
   endfunction

endpackage

// ===== rtl/dhs_req_if.sv =====
// Request channel of the dual hash seal engine: valid, ready and one
// input word. Depends on nothing.
interface dhs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  data_byte;
   logic [63:0] timestamp;

   modport source (output valid, command, data_byte, timestamp, input ready);
   modport sink   (input valid, command, data_byte, timestamp, output ready);
endinterface

// ===== rtl/dhs_rsp_if.sv =====
// Response channel of the dual hash seal engine: valid, ready and the three
// seal words. Depends on nothing.
interface dhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] seal_low;
   logic [63:0] seal_mid;
   logic [63:0] seal_high;

   modport source (output valid, seal_low, seal_mid, seal_high, input ready);
   modport sink   (input valid, seal_low, seal_mid, seal_high, output ready);
endinterface

// ===== rtl/dhs_front.sv =====
// Front end: takes request words and turns each into a queue word that
// tells the back end what to do. Depends on dhs_pkg and dhs_req_if.
module dhs_front
   import dhs_pkg::*;
(
   dhs_req_if.sink   req_ch,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      if (req_ch.command) begin
         push_entry.op      = OP_FINISH;
         push_entry.operand = req_ch.timestamp;
      end else begin
         push_entry.op      = OP_ABSORB;
         push_entry.operand = {56'd0, req_ch.data_byte};
      end
   end

endmodule

// ===== rtl/dhs_queue.sv =====
// Short first-in first-out queue of classified words between the front
// and back ends. Depends on dhs_pkg.
module dhs_queue
   import dhs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   entry_type         store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !(push && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty but pointers differ");

endmodule

// ===== rtl/dhs_back.sv =====
// Back end: runs the two hash chains on queued words and holds the seal in
// an output register until it is taken. Depends on dhs_pkg and dhs_rsp_if.
module dhs_back
   import dhs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   dhs_rsp_if.source rsp_ch
);

   logic [63:0] djb_ff, djb_in;
   logic [63:0] fnv_ff, fnv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] seal_low_ff, seal_mid_ff, seal_high_ff;
   logic [63:0] fold_djb, fold_fnv;
   logic        load_seal;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.seal_low  = seal_low_ff;
   assign rsp_ch.seal_mid  = seal_mid_ff;
   assign rsp_ch.seal_high = seal_high_ff;

   assign fold_djb = djb_ff ^ head_entry.operand;
   assign fold_fnv = fnv_mul(fnv_ff ^ head_entry.operand);

   always_comb begin
      pop          = 1'b0;
      load_seal    = 1'b0;
      djb_in       = djb_ff;
      fnv_in       = fnv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (head_valid) begin
         case (head_entry.op)
            OP_ABSORB: begin
               pop    = 1'b1;
               djb_in = ((djb_ff << 5) + djb_ff) ^ head_entry.operand;
               fnv_in = fold_fnv;
            end
            OP_FINISH: begin
               // A seal waits here until the output register has room.
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  pop          = 1'b1;
                  load_seal    = 1'b1;
                  rsp_valid_in = 1'b1;
                  djb_in       = DJB_START;
                  fnv_in       = FNV_BASIS;
               end
            end
            default: begin
               pop = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         djb_ff       <= DJB_START;
         fnv_ff       <= FNV_BASIS;
         rsp_valid_ff <= 1'b0;
      end else begin
         djb_ff       <= djb_in;
         fnv_ff       <= fnv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_seal) begin
         seal_low_ff  <= fold_djb;
         seal_mid_ff  <= fold_fnv;
         seal_high_ff <= fold_djb ^ fold_fnv;
      end
   end

   a_restart_after_seal: assert property (@(posedge clock) disable iff (reset)
      load_seal |=> (djb_ff == DJB_START) && (fnv_ff == FNV_BASIS))
      else $error("hashes did not restart after a seal");

   a_seal_xor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (seal_high_ff == (seal_low_ff ^ seal_mid_ff)))
      else $error("third seal word is not the XOR of the first two");

   a_no_seal_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_seal |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("pending seal overwritten");

endmodule

// ===== rtl/dual_hash_seal_engine.sv =====
// Dual hash seal engine. Each request word either absorbs one message byte
// into a djb2-style hash (times 33, then XOR) and an FNV-1a 64 hash, or
// finishes the message: the timestamp is XORed into both hashes, the FNV
// hash gets one more multiply, and one response word carries the two hashes
// and their XOR, after which both hashes restart. The engine takes one
// request word per cycle while the queue is not full; the FNV multiply is a
// fixed sum of shifts, so each hash update is combinational. A four-word
// queue sits between request acceptance and the hash unit, and the seal sits
// in an output register, so requests keep flowing while a seal waits. Only a
// finish word blocks the hash unit, and only while the previous seal has not
// been taken. An accepted finish word is held in the queue, and its seal then
// in the output register, before the seal appears on the response port.
module dual_hash_seal_engine
   import dhs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dhs_req_if.sink   req_ch,
   dhs_rsp_if.source rsp_ch
);

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   dhs_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   dhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   dhs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== tb/dual_hash_seal_engine_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the dual hash seal engine: drives request words, predicts every
// seal and compares it with the response channel. Depends on dhs_pkg and the
// two channel interfaces.
module dual_hash_seal_engine_tb;
   import dhs_pkg::*;

   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      op_type      op;
      logic [7:0]  data_byte;
      logic [63:0] timestamp;
   } req_word_type;

   typedef struct {
      logic [63:0] low;
      logic [63:0] mid;
      logic [63:0] high;
   } seal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dhs_req_if req_ch ();
   dhs_rsp_if rsp_ch ();

   dual_hash_seal_engine dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   req_word_type pending_words[$];
   seal_type     seal_expected[$];
   logic [63:0]  djb_state = DJB_START;
   logic [63:0]  fnv_state = FNV_BASIS;
   int           words_accepted = 0;
   int           error_count = 0;
   logic         req_word_taken = 1'b0;
   int           hold_off_left = 0;
   logic         hold_off_done = 1'b0;
   logic         quiet_stretch;

   // Neither side idles while this window of accepted words passes.
   assign quiet_stretch = (words_accepted >= 600) && (words_accepted < 800);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance both hashes by one accepted word; a finish word yields a seal.
   task automatic seal_predict(input req_word_type w);
      logic [63:0] low_word;
      logic [63:0] mid_word;
      if (w.op == OP_ABSORB) begin
         djb_state = (djb_state * 64'd33) ^ {56'd0, w.data_byte};
         fnv_state = (fnv_state ^ {56'd0, w.data_byte}) * FNV_PRIME;
      end else begin
         low_word  = djb_state ^ w.timestamp;
         mid_word  = (fnv_state ^ w.timestamp) * FNV_PRIME;
         seal_expected.push_back('{low_word, mid_word, low_word ^ mid_word});
         djb_state = DJB_START;
         fnv_state = FNV_BASIS;
      end
   endtask

   task automatic push_absorb(input logic [7:0] value);
      pending_words.push_back('{OP_ABSORB, value, {$urandom, $urandom}});
   endtask

   task automatic push_finish(input logic [7:0] value, input logic [63:0] stamp);
      pending_words.push_back('{OP_FINISH, value, stamp});
   endtask

   task automatic compare_word(input string label, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         error_count++;
      end
   endtask

   function automatic logic [63:0] random_stamp();
      case ($urandom_range(7))
         0: random_stamp = 64'd0;
         1: random_stamp = ALL_ONES;
         default: random_stamp = {$urandom, $urandom};
      endcase
   endfunction

   // Request driver: a word stays on the port until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.command   <= OP_ABSORB;
         req_ch.data_byte <= 8'd0;
         req_ch.timestamp <= 64'd0;
      end else if (req_ch.valid && !req_word_taken) begin
         req_ch.valid <= 1'b1;
      end else if (pending_words.size() != 0 &&
                   (quiet_stretch || $urandom_range(99) >= 13)) begin
         req_ch.valid     <= 1'b1;
         req_ch.command   <= pending_words[0].op;
         req_ch.data_byte <= pending_words[0].data_byte;
         req_ch.timestamp <= pending_words[0].timestamp;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_word_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         seal_predict(pending_words[0]);
         void'(pending_words.pop_front());
         words_accepted++;
      end
   end

   // Response side: random stalls plus one long hold-off so the queue fills.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_ch.ready  <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (!hold_off_done && words_accepted >= 300) begin
         rsp_ch.ready  <= 1'b0;
         hold_off_done <= 1'b1;
         hold_off_left <= 400;
      end else begin
         rsp_ch.ready <= quiet_stretch || $urandom_range(99) >= 13;
      end
   end

   always @(posedge clock) begin : seal_monitor
      seal_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (seal_expected.size() == 0) begin
            $display("%0t: unexpected seal word, expected none, actual %h %h %h", $time,
                     rsp_ch.seal_low, rsp_ch.seal_mid, rsp_ch.seal_high);
            error_count++;
         end else begin
            want = seal_expected.pop_front();
            compare_word("seal_low", want.low, rsp_ch.seal_low);
            compare_word("seal_mid", want.mid, rsp_ch.seal_mid);
            compare_word("seal_high", want.high, rsp_ch.seal_high);
         end
      end
   end

   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int msg_len;

      // Empty messages right after reset, at both timestamp extremes.
      push_finish(8'h00, 64'd0);
      push_finish(8'hFF, ALL_ONES);
      push_absorb(8'h00);
      push_absorb(8'hFF);
      push_finish(8'h00, 64'd0);
      push_absorb(8'hFF);
      push_absorb(8'hFF);
      push_absorb(8'hFF);
      push_finish(8'h5A, ALL_ONES);
      push_absorb(8'h55);
      push_absorb(8'hAA);
      push_absorb(8'h01);
      push_absorb(8'h80);
      push_finish(8'h00, 64'h5555_5555_AAAA_AAAA);
      // Back-to-back finishes; the data byte of a finish must be ignored.
      push_finish(8'hFF, 64'h8000_0000_0000_0001);
      push_finish(8'h7E, 64'hAAAA_AAAA_5555_5555);
      push_absorb(8'h00);
      push_finish(8'hC3, 64'h0123_4567_89AB_CDEF);

      while (pending_words.size() < 1100) begin
         msg_len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
         repeat (msg_len) push_absorb(8'($urandom_range(255)));
         push_finish(8'($urandom_range(255)), random_stamp());
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      while (seal_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dhs_pkg.sv
rtl/dhs_req_if.sv
rtl/dhs_rsp_if.sv
rtl/dhs_front.sv
rtl/dhs_queue.sv
rtl/dhs_back.sv
rtl/dual_hash_seal_engine.sv
tb/dual_hash_seal_engine_tb.sv
